### design/lbs_pkg.sv
// Package for the longest bitonic subsequence block.
// Holds the sequencer state type and the fixed widths of the result ports.
// No dependencies.
`default_nettype none

package lbs_pkg;

  // Fixed widths of the result fields.
  localparam int ELEM_W   = 32;
  localparam int LENGTH_W = 6;

  // Sequencer states.
  typedef enum logic [4:0] {
    S_IDLE,
    S_R_HEAD,
    S_R_VI,
    S_R_SCAN,
    S_R_WR,
    S_F_HEAD,
    S_F_VI,
    S_F_SCAN,
    S_F_WR,
    S_W_INIT,
    S_W_RD,
    S_W_NX,
    S_E_STK,
    S_E_VAL,
    S_E_OUT,
    S_D_RD,
    S_D_OUT
  } state_e;

endpackage

`default_nettype wire

### design/longest_bitonic_subsequence.sv
// Top level of the longest bitonic subsequence block.
// Depends on lbs_pkg for the sequencer state type and the result widths.
// Holds the element, run and stack memories and the sequencer around them.
//
// Usage:
//   Input beats (value_i, last_i) are taken at a rising edge where start_i is
//   high and busy_o is low. While the sequence is loading, busy_o stays low and
//   one beat is stored per cycle; beats beyond MAX_ELEMENTS are dropped and
//   flagged on overflow_o. The beat with last_i set closes the sequence.
//   After that the block raises busy_o and runs two passes over the element
//   memory: an increasing pass left to right and a decreasing pass right to
//   left, in which the peak is found as well. For each element i the
//   increasing pass scans the elements below i and the decreasing pass those
//   above i, through the single read port of the element memory. Then the
//   chain of the rising part is walked back from the peak into the stack.
//   Results then follow as strobe_o pulses: for each element of the rising
//   part a stack read, an element read and the output, then for the falling
//   part an element read and the output, after a lookup of the peak that
//   outputs nothing. Each result is shown for exactly one cycle; the receiver
//   cannot stall. busy_o drops the cycle after the last result, which has
//   end_of_run_o set, or, when the falling part is empty, once the peak
//   lookup (S_D_RD, S_D_OUT) is done.
//   Reset (rst_ni low) empties the sequence and returns to loading. The
//   memories are not cleared; only entries of the current sequence are read.
`default_nettype none

module longest_bitonic_subsequence #(
  parameter int MAX_ELEMENTS = 32,
  parameter int VALUE_BITS   = 32
) (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  input  wire                                 start_i,
  output logic                                busy_o,
  input  wire  signed [VALUE_BITS-1:0]        value_i,
  input  wire                                 last_i,
  output logic                                strobe_o,
  output logic signed [lbs_pkg::ELEM_W-1:0]   element_o,
  output logic [lbs_pkg::LENGTH_W-1:0]        length_o,
  output logic                                end_of_run_o,
  output logic                                overflow_o
);

  import lbs_pkg::*;

  // Index width and run length width.
  localparam int IW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
  localparam int LW = $clog2(MAX_ELEMENTS + 1);
  localparam int EW = LW + IW;

  // Memories: elements, rise entries {length, prev}, fall entries
  // {length, next}, and the stack that puts the rising chain in order.
  logic signed [VALUE_BITS-1:0] val_mem   [MAX_ELEMENTS];
  logic [EW-1:0]                rise_mem  [MAX_ELEMENTS];
  logic [EW-1:0]                fall_mem  [MAX_ELEMENTS];
  logic [IW-1:0]                stack_mem [MAX_ELEMENTS];

  logic signed [VALUE_BITS-1:0] rd_v_q;
  logic [EW-1:0]                rd_r_q;
  logic [EW-1:0]                rd_f_q;
  logic [IW-1:0]                rd_s_q;

  logic [IW-1:0] v_raddr, r_raddr, f_raddr, s_raddr;
  logic          v_we, r_we, f_we, s_we;
  logic [IW-1:0] v_waddr, rf_waddr, s_waddr;
  logic [EW-1:0] rf_wdata;
  logic [IW-1:0] s_wdata;

  // Control and working registers.
  state_e                       state_q, state_d;
  logic [LW-1:0]                cnt_q, cnt_d;
  logic                         dropped_q, dropped_d;
  logic [IW-1:0]                last_idx_q, last_idx_d;
  logic [IW-1:0]                i_q, i_d;
  logic [IW-1:0]                j_q, j_d;
  logic                         pv_q, pv_d;
  logic [IW-1:0]                pj_q, pj_d;
  logic signed [VALUE_BITS-1:0] vi_q, vi_d;
  logic [LW-1:0]                cur_len_q, cur_len_d;
  logic [IW-1:0]                cur_ptr_q, cur_ptr_d;
  logic [LW-1:0]                rl_i_q, rl_i_d;
  logic [LW-1:0]                best_q, best_d;
  logic [IW-1:0]                peak_q, peak_d;
  logic [LW-1:0]                pk_rl_q, pk_rl_d;
  logic [LW-1:0]                pk_fl_q, pk_fl_d;
  logic [IW-1:0]                w_idx_q, w_idx_d;
  logic [IW-1:0]                k_q, k_d;
  logic [LW-1:0]                em_q, em_d;

  logic                         out_valid_q, out_valid_d;
  logic signed [ELEM_W-1:0]     out_elem_q, out_elem_d;
  logic                         out_eor_q, out_eor_d;
  logic                         out_ovf_q, out_ovf_d;

  // Decoded fields of the registered read data.
  logic [LW-1:0] rd_r_len, rd_f_len;
  logic [IW-1:0] rd_r_ptr, rd_f_ptr;
  logic          v_less;
  logic [LW:0]   total;

  assign rd_r_len = rd_r_q[EW-1:IW];
  assign rd_r_ptr = rd_r_q[IW-1:0];
  assign rd_f_len = rd_f_q[EW-1:IW];
  assign rd_f_ptr = rd_f_q[IW-1:0];
  assign v_less   = (rd_v_q < vi_q);
  assign total    = {1'b0, rl_i_q} + {1'b0, cur_len_q} - (LW + 1)'(1);

  // Element memory: one write port for loading, one registered read port.
  always_ff @(posedge clk_i) begin
    if (v_we) begin
      val_mem[v_waddr] <= value_i;
    end
    rd_v_q <= val_mem[v_raddr];
  end

  // Rise and fall run memories.
  always_ff @(posedge clk_i) begin
    if (r_we) begin
      rise_mem[rf_waddr] <= rf_wdata;
    end
    rd_r_q <= rise_mem[r_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (f_we) begin
      fall_mem[rf_waddr] <= rf_wdata;
    end
    rd_f_q <= fall_mem[f_raddr];
  end

  // Ordering stack for the rising chain.
  always_ff @(posedge clk_i) begin
    if (s_we) begin
      stack_mem[s_waddr] <= s_wdata;
    end
    rd_s_q <= stack_mem[s_raddr];
  end

  // State and control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      dropped_q   <= 1'b0;
      pv_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      dropped_q   <= dropped_d;
      pv_q        <= pv_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Working and result payload registers.
  always_ff @(posedge clk_i) begin
    last_idx_q <= last_idx_d;
    i_q        <= i_d;
    j_q        <= j_d;
    pj_q       <= pj_d;
    vi_q       <= vi_d;
    cur_len_q  <= cur_len_d;
    cur_ptr_q  <= cur_ptr_d;
    rl_i_q     <= rl_i_d;
    best_q     <= best_d;
    peak_q     <= peak_d;
    pk_rl_q    <= pk_rl_d;
    pk_fl_q    <= pk_fl_d;
    w_idx_q    <= w_idx_d;
    k_q        <= k_d;
    em_q       <= em_d;
    out_elem_q <= out_elem_d;
    out_eor_q  <= out_eor_d;
    out_ovf_q  <= out_ovf_d;
  end

  // Sequencer: loading, two run passes, chain walk and emission.
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    dropped_d   = dropped_q;
    last_idx_d  = last_idx_q;
    i_d         = i_q;
    j_d         = j_q;
    pv_d        = 1'b0;
    pj_d        = pj_q;
    vi_d        = vi_q;
    cur_len_d   = cur_len_q;
    cur_ptr_d   = cur_ptr_q;
    rl_i_d      = rl_i_q;
    best_d      = best_q;
    peak_d      = peak_q;
    pk_rl_d     = pk_rl_q;
    pk_fl_d     = pk_fl_q;
    w_idx_d     = w_idx_q;
    k_d         = k_q;
    em_d        = em_q;
    out_valid_d = 1'b0;
    out_elem_d  = out_elem_q;
    out_eor_d   = out_eor_q;
    out_ovf_d   = out_ovf_q;
    v_raddr     = '0;
    r_raddr     = '0;
    f_raddr     = '0;
    s_raddr     = '0;
    v_we        = 1'b0;
    r_we        = 1'b0;
    f_we        = 1'b0;
    s_we        = 1'b0;
    v_waddr     = cnt_q[IW-1:0];
    rf_waddr    = i_q;
    rf_wdata    = {cur_len_q, cur_ptr_q};
    s_waddr     = k_q;
    s_wdata     = w_idx_q;

    case (state_q)
      // Store incoming beats; the last one starts the evaluation.
      S_IDLE: begin
        if (start_i && !out_valid_q) begin
          if (cnt_q < LW'(MAX_ELEMENTS)) begin
            v_we  = 1'b1;
            cnt_d = cnt_q + LW'(1);
          end else begin
            dropped_d = 1'b1;
          end
          if (last_i) begin
            last_idx_d = (cnt_q < LW'(MAX_ELEMENTS)) ? cnt_q[IW-1:0]
                                                     : IW'(MAX_ELEMENTS - 1);
            i_d     = '0;
            best_d  = '0;
            state_d = S_R_HEAD;
          end
        end
      end

      // Increasing pass: fetch element i, then scan j below it.
      S_R_HEAD: begin
        v_raddr = i_q;
        state_d = S_R_VI;
      end
      S_R_VI: begin
        vi_d      = rd_v_q;
        cur_len_d = LW'(1);
        cur_ptr_d = i_q;
        j_d       = '0;
        state_d   = S_R_SCAN;
      end
      S_R_SCAN: begin
        if (pv_q && v_less && ({1'b0, rd_r_len} + (LW + 1)'(1) > {1'b0, cur_len_q})) begin
          cur_len_d = rd_r_len + LW'(1);
          cur_ptr_d = pj_q;
        end
        if (j_q < i_q) begin
          v_raddr = j_q;
          r_raddr = j_q;
          pv_d    = 1'b1;
          pj_d    = j_q;
          j_d     = j_q + IW'(1);
        end else if (!pv_q) begin
          state_d = S_R_WR;
        end
      end
      S_R_WR: begin
        r_we = 1'b1;
        if (i_q == last_idx_q) begin
          state_d = S_F_HEAD;
        end else begin
          i_d     = i_q + IW'(1);
          state_d = S_R_HEAD;
        end
      end

      // Decreasing pass: fetch element i and its rise length, scan j above.
      S_F_HEAD: begin
        v_raddr = i_q;
        r_raddr = i_q;
        state_d = S_F_VI;
      end
      S_F_VI: begin
        vi_d      = rd_v_q;
        rl_i_d    = rd_r_len;
        cur_len_d = LW'(1);
        cur_ptr_d = i_q;
        j_d       = last_idx_q;
        state_d   = S_F_SCAN;
      end
      S_F_SCAN: begin
        if (pv_q && v_less && ({1'b0, rd_f_len} + (LW + 1)'(1) > {1'b0, cur_len_q})) begin
          cur_len_d = rd_f_len + LW'(1);
          cur_ptr_d = pj_q;
        end
        if (j_q > i_q) begin
          v_raddr = j_q;
          f_raddr = j_q;
          pv_d    = 1'b1;
          pj_d    = j_q;
          j_d     = j_q - IW'(1);
        end else if (!pv_q) begin
          state_d = S_F_WR;
        end
      end
      S_F_WR: begin
        f_we = 1'b1;
        // Descending scan with >= keeps the lowest index of the best sum.
        if (total >= {1'b0, best_q}) begin
          best_d  = total[LW-1:0];
          peak_d  = i_q;
          pk_rl_d = rl_i_q;
          pk_fl_d = cur_len_q;
        end
        if (i_q == '0) begin
          state_d = S_W_INIT;
        end else begin
          i_d     = i_q - IW'(1);
          state_d = S_F_HEAD;
        end
      end

      // Walk the rising chain back from the peak into the stack.
      S_W_INIT: begin
        w_idx_d = peak_q;
        k_d     = IW'(pk_rl_q - LW'(1));
        state_d = S_W_RD;
      end
      S_W_RD: begin
        s_we    = 1'b1;
        r_raddr = w_idx_q;
        if (k_q == '0) begin
          em_d    = '0;
          state_d = S_E_STK;
        end else begin
          state_d = S_W_NX;
        end
      end
      S_W_NX: begin
        w_idx_d = rd_r_ptr;
        k_d     = k_q - IW'(1);
        state_d = S_W_RD;
      end

      // Emit the rising part in order through the stack.
      S_E_STK: begin
        s_raddr = k_q;
        state_d = S_E_VAL;
      end
      S_E_VAL: begin
        v_raddr = rd_s_q;
        state_d = S_E_OUT;
      end
      S_E_OUT: begin
        out_valid_d = 1'b1;
        out_elem_d  = ELEM_W'(rd_v_q);
        out_eor_d   = ({1'b0, em_q} + (LW + 1)'(1) == {1'b0, best_q});
        out_ovf_d   = dropped_q;
        em_d        = em_q + LW'(1);
        if (LW'(k_q) + LW'(1) == pk_rl_q) begin
          w_idx_d = peak_q;
          k_d     = '0;
          state_d = S_D_RD;
        end else begin
          k_d     = k_q + IW'(1);
          state_d = S_E_STK;
        end
      end

      // Follow the falling chain; the peak itself was already emitted.
      S_D_RD: begin
        v_raddr = w_idx_q;
        f_raddr = w_idx_q;
        state_d = S_D_OUT;
      end
      S_D_OUT: begin
        if (k_q != '0) begin
          out_valid_d = 1'b1;
          out_elem_d  = ELEM_W'(rd_v_q);
          out_eor_d   = ({1'b0, em_q} + (LW + 1)'(1) == {1'b0, best_q});
          out_ovf_d   = dropped_q;
          em_d        = em_q + LW'(1);
        end
        w_idx_d = rd_f_ptr;
        if (LW'(k_q) + LW'(1) == pk_fl_q) begin
          cnt_d     = '0;
          dropped_d = 1'b0;
          state_d   = S_IDLE;
        end else begin
          k_d     = k_q + IW'(1);
          state_d = S_D_RD;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Result ports.
  assign busy_o       = (state_q != S_IDLE) || out_valid_q;
  assign strobe_o     = out_valid_q;
  assign element_o    = out_elem_q;
  assign length_o     = LENGTH_W'(best_q);
  assign end_of_run_o = out_eor_q;
  assign overflow_o   = out_ovf_q;

  // The fill count never passes the capacity.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= LW'(MAX_ELEMENTS))
    else $error("element count beyond capacity");

  // The increasing scan never reads at or beyond the element being solved.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_R_SCAN && pv_q) |-> (pj_q < i_q))
    else $error("increasing scan read out of range");

  // No more results than the subsequence length.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o |-> (em_q <= best_q))
    else $error("more results than the subsequence length");

  // A closing beat always starts the evaluation.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && last_i) |=> busy_o)
    else $error("closing beat did not start evaluation");

endmodule

`default_nettype wire
